// ===== sv/tgad_pkg.sv =====
// ----------------------------------------------------------------------------
// tgad_pkg
// shared types and constants of the tga stream decoder
// ----------------------------------------------------------------------------
package tgad_pkg;

    localparam int unsigned HDR_LEN = 18;

    localparam logic [7:0] TYPE_TRUECOLOUR = 8'd2;
    localparam logic [7:0] TYPE_GREY       = 8'd3;
    localparam logic [7:0] BPP_BGRA        = 8'd24;
    localparam logic [7:0] BPP_GRAY        = 8'd8;
    localparam logic [7:0] ALPHA_MASK      = 8'h0f;
    localparam logic [7:0] OPAQUE          = 8'hff;

    // index of the last byte of a b,g,r triplet
    localparam logic [1:0] LAST_BGR_BYTE = 2'd2;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_PIXELS = 4'b0100,
        PH_TAIL   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [16:0] pos_x;
        logic [15:0] pos_y;
        logic [31:0] argb;
        logic [16:0] surface_width;
        logic [16:0] surface_height;
        logic        success;
        logic        image_complete;
    } result_t;

    // what one file byte leaves behind: one result, perhaps a second
    typedef struct packed {
        result_t first;
        logic    has_second;
        result_t second;
    } bundle_t;

endpackage

// ===== sv/tgad_stream_if.sv =====
// ----------------------------------------------------------------------------
// tgad_stream_if
// valid/ready channel carrying one item of type T
// ----------------------------------------------------------------------------
interface tgad_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tgad_parse.sv =====
// ----------------------------------------------------------------------------
// tgad_parse
// front part: header capture and check, skip count, pixel assembly
// ----------------------------------------------------------------------------
module tgad_parse
    import tgad_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tgad_stream_if.sink   bytes,
    tgad_stream_if.source events
);

    phase_t      phase_reg,         phase_next;
    logic [4:0]  header_index_reg,  header_index_next;
    logic [20:0] skip_count_reg,    skip_count_next;
    logic [15:0] column_reg,        column_next;
    logic [15:0] row_reg,           row_next;
    logic [15:0] partial_pixel_reg, partial_pixel_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic        failed_reg,        failed_next;
    logic        done_reg,          done_next;

    logic [7:0]  hdr_reg [HDR_LEN];

    byte_item_t  item;
    logic        acc;
    logic [7:0]  b;

    logic [15:0] start_x, start_y, width, height, map_len;
    logic [23:0] map_bits;
    logic [24:0] skip_full;
    logic [20:0] skip_calc;
    logic        hdr_ok;
    logic        empty_image;

    logic [31:0] argb;
    logic        pix_out;
    result_t     res_a;
    logic        has_a;
    bundle_t     bundle;

    assign item  = bytes.data;
    assign acc   = bytes.valid && bytes.ready;
    assign b     = item.file_byte;
    assign bytes.ready = events.ready;

    assign start_x = {hdr_reg[9],  hdr_reg[8]};
    assign start_y = {hdr_reg[11], hdr_reg[10]};
    assign width   = {hdr_reg[13], hdr_reg[12]};
    assign height  = {hdr_reg[15], hdr_reg[14]};
    assign map_len = {hdr_reg[6],  hdr_reg[5]};

    // colour-map bytes: ceil(entries * bits / 8), plus the id field
    assign map_bits  = 24'(map_len) * 24'(hdr_reg[7]);
    assign skip_full = ((25'(map_bits) + 25'd7) >> 3) + 25'(hdr_reg[0]);
    assign skip_calc = skip_full[20:0];

    // descriptor byte is the one arriving now
    assign hdr_ok = (hdr_reg[1] == 8'd0)
                 && (((hdr_reg[2] == TYPE_TRUECOLOUR) && (hdr_reg[16] == BPP_BGRA))
                  || ((hdr_reg[2] == TYPE_GREY) && (hdr_reg[16] == BPP_GRAY)))
                 && ((b & ALPHA_MASK) == 8'd0);

    assign empty_image = (width == 16'd0) || (height == 16'd0);

    always_ff @(posedge clk)
    begin
        if (acc && (phase_reg == PH_HEADER) && (header_index_reg < 5'(HDR_LEN)))
        begin
            hdr_reg[header_index_reg] <= b;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        header_index_next  = header_index_reg;
        skip_count_next    = skip_count_reg;
        column_next        = column_reg;
        row_next           = row_reg;
        partial_pixel_next = partial_pixel_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        failed_next        = failed_reg;
        done_next          = done_reg;
        res_a              = '0;
        has_a              = 1'b0;
        argb               = '0;
        pix_out            = 1'b0;
        bundle             = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                header_index_next = header_index_reg + 5'd1;
                if (header_index_reg == 5'(HDR_LEN - 1))
                begin
                    if (!hdr_ok)
                    begin
                        failed_next = 1'b1;
                        phase_next  = PH_TAIL;
                    end
                    else
                    begin
                        has_a                = 1'b1;
                        res_a.kind           = KIND_HEADER;
                        res_a.surface_width  = 17'(start_x) + 17'(width);
                        res_a.surface_height = 17'(start_y) + 17'(height);
                        skip_count_next      = skip_calc;
                        if (skip_calc != 21'd0)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if (empty_image)
                        begin
                            done_next  = 1'b1;
                            phase_next = PH_TAIL;
                        end
                        else
                        begin
                            phase_next = PH_PIXELS;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                skip_count_next = skip_count_reg - 21'd1;
                if (skip_count_reg == 21'd1)
                begin
                    if (empty_image)
                    begin
                        done_next  = 1'b1;
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        phase_next = PH_PIXELS;
                    end
                end
            end
            PH_PIXELS:
            begin
                if (hdr_reg[2] == TYPE_TRUECOLOUR)
                begin
                    if (byte_in_pixel_reg < LAST_BGR_BYTE)
                    begin
                        partial_pixel_next = {partial_pixel_reg[7:0], b};
                        byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
                    end
                    else
                    begin
                        byte_in_pixel_next = 2'd0;
                        partial_pixel_next = 16'd0;
                        argb    = {OPAQUE, b, partial_pixel_reg[7:0], partial_pixel_reg[15:8]};
                        pix_out = 1'b1;
                    end
                end
                else
                begin
                    argb    = {OPAQUE, b, b, b};
                    pix_out = 1'b1;
                end

                if (pix_out)
                begin
                    has_a       = 1'b1;
                    res_a.kind  = KIND_PIXEL;
                    res_a.pos_x = 17'(start_x) + 17'(column_reg);
                    res_a.pos_y = height - 16'd1 - row_reg;
                    res_a.argb  = argb;
                    if ((column_reg + 16'd1) == width)
                    begin
                        column_next = 16'd0;
                        if ((row_reg + 16'd1) == height)
                        begin
                            res_a.image_complete = 1'b1;
                            done_next            = 1'b1;
                            phase_next           = PH_TAIL;
                        end
                        else
                        begin
                            row_next = row_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        column_next = column_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                // tail: trailing bytes or rejected header, nothing to do
            end
        endcase

        if (item.end_of_file)
        begin
            if (has_a)
            begin
                bundle.first              = res_a;
                bundle.has_second         = 1'b1;
                bundle.second.kind        = KIND_STATUS;
                bundle.second.success     = done_next && !failed_next;
            end
            else
            begin
                bundle.first.kind         = KIND_STATUS;
                bundle.first.success      = done_next && !failed_next;
            end
            phase_next         = PH_HEADER;
            header_index_next  = 5'd0;
            skip_count_next    = 21'd0;
            column_next        = 16'd0;
            row_next           = 16'd0;
            partial_pixel_next = 16'd0;
            byte_in_pixel_next = 2'd0;
            failed_next        = 1'b0;
            done_next          = 1'b0;
        end
        else
        begin
            bundle.first = res_a;
        end
    end

    assign events.valid = bytes.valid && (has_a || item.end_of_file);
    assign events.data  = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            header_index_reg  <= 5'd0;
            skip_count_reg    <= 21'd0;
            column_reg        <= 16'd0;
            row_reg           <= 16'd0;
            partial_pixel_reg <= 16'd0;
            byte_in_pixel_reg <= 2'd0;
            failed_reg        <= 1'b0;
            done_reg          <= 1'b0;
        end
        else if (acc)
        begin
            phase_reg         <= phase_next;
            header_index_reg  <= header_index_next;
            skip_count_reg    <= skip_count_next;
            column_reg        <= column_next;
            row_reg           <= row_next;
            partial_pixel_reg <= partial_pixel_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            failed_reg        <= failed_next;
            done_reg          <= done_next;
        end
    end

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_count_reg != 21'd0))
        else $error("skip phase entered with nothing to skip");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && item.end_of_file) |=> ((phase_reg == PH_HEADER) && (header_index_reg == 5'd0)))
        else $error("decoder not back at header after end of file");

endmodule

// ===== sv/tgad_queue.sv =====
// ----------------------------------------------------------------------------
// tgad_queue
// short fifo of result bundles between parser and output stage
// ----------------------------------------------------------------------------
module tgad_queue
    import tgad_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    tgad_stream_if.sink   push_side,
    tgad_stream_if.source pop_side
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bundle_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               push, pop;

    assign push_side.ready = (count_reg != CNT_W'(DEPTH));
    assign pop_side.valid  = (count_reg != '0);
    assign pop_side.data   = slot_reg[rd_ptr_reg];

    assign push = push_side.valid && push_side.ready;
    assign pop  = pop_side.valid && pop_side.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_side.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// ===== sv/tgad_emit.sv =====
// ----------------------------------------------------------------------------
// tgad_emit
// back part: splits bundles into single results behind an output register
// ----------------------------------------------------------------------------
module tgad_emit
    import tgad_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tgad_stream_if.sink   events,
    tgad_stream_if.source results
);

    result_t out_reg,        out_next;
    logic    out_valid_reg,  out_valid_next;
    result_t pend_reg,       pend_next;
    logic    pend_valid_reg, pend_valid_next;
    logic    can_load;
    bundle_t bundle;

    assign bundle         = events.data;
    assign can_load       = !out_valid_reg || results.ready;
    assign events.ready   = can_load && !pend_valid_reg;
    assign results.valid  = out_valid_reg;
    assign results.data   = out_reg;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (can_load)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (events.valid)
            begin
                out_next        = bundle.first;
                out_valid_next  = 1'b1;
                pend_next       = bundle.second;
                pend_valid_next = bundle.has_second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second result held with no first result in front");

endmodule

// ===== sv/tga_image_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tga_image_stream_decoder_unit
// uncompressed tga decoder: header check, id/colour-map skip, argb pixels
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                               handshake
//  bytes     in   file_byte[7:0], end_of_file           valid/ready
//  results   out  kind, pos_x, pos_y, argb,             valid/ready
//                 surface_width, surface_height,
//                 success, image_complete
//
//  one byte is taken per cycle while the queue has room; the parser finishes
//  each byte in the cycle it is accepted, so a byte never waits on the one
//  before it; a result passes through the queue and then the output register
//  before it reaches the port; a byte that yields two results (end of file
//  with a pixel or header) keeps the output stage from taking the next
//  bundle until its second result has moved into the output register
//  rst_n clears all control state at once; no clearing pass is needed
//  bytes stall only when the queue is full, results stall only the output
//  register and, through it, the queue
//
module tga_image_stream_decoder_unit
    import tgad_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    tgad_stream_if.sink   bytes,
    tgad_stream_if.source results
);

    // parser to queue, queue to output stage
    tgad_stream_if #(.T(bundle_t)) parsed ();
    tgad_stream_if #(.T(bundle_t)) queued ();

    // front: classifies every byte, builds up to two results per byte
    tgad_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes),
        .events (parsed)
    );

    // decouples parsing from output back-pressure
    tgad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_side (parsed),
        .pop_side  (queued)
    );

    // back: hands results out one at a time from a register
    tgad_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (queued),
        .results (results)
    );

endmodule
